// ===== sv/oct_pkg.sv =====
// Shared types and constants for the ordered change tracker.
// No dependencies; the interfaces and the top level take names from here.
package oct_pkg;

    localparam int unsigned DEF_ENTITIES = 1024;
    localparam int unsigned ENTITY_W     = 10;
    localparam int unsigned COUNT_W      = 11;
    localparam int unsigned CMD_W        = 2;
    localparam int unsigned LINK_W       = 2;
    localparam int unsigned WIDE_W       = 17;

    localparam logic [CMD_W-1:0] CMD_RECORD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    localparam logic [LINK_W-1:0] LINK_OUT  = 2'd0;
    localparam logic [LINK_W-1:0] LINK_NEXT = 2'd1;
    localparam logic [LINK_W-1:0] LINK_TAIL = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_E,
        ST_REC_TAIL,
        ST_WALK,
        ST_UNLINK,
        ST_FINISH
    } state_t;

endpackage

// ===== sv/oct_if.sv =====
// Valid/ready channel interfaces for command words and result words.
// Depends on oct_pkg for field widths.
interface oct_in_if;
    logic                           valid;
    logic                           ready;
    logic [oct_pkg::CMD_W-1:0]      command;
    logic [oct_pkg::ENTITY_W-1:0]   entity;

    modport source (output valid, output command, output entity, input ready);
    modport sink   (input valid, input command, input entity, output ready);
endinterface

interface oct_out_if;
    logic                           valid;
    logic                           ready;
    logic [oct_pkg::LINK_W-1:0]     link_status;
    logic [oct_pkg::ENTITY_W-1:0]   next_entity;
    logic [oct_pkg::ENTITY_W-1:0]   head_entity;
    logic                           list_empty;
    logic [oct_pkg::COUNT_W-1:0]    change_count;
    logic                           list_altered;

    modport source (output valid, output link_status, output next_entity,
                    output head_entity, output list_empty, output change_count,
                    output list_altered, input ready);
    modport sink   (input valid, input link_status, input next_entity,
                    input head_entity, input list_empty, input change_count,
                    input list_altered, output ready);
endinterface

// ===== sv/ordered_change_tracker.sv =====
// Ordered change tracker: a first-come list of changed entities without duplicates,
// threaded through a per-entity link memory. Depends on oct_pkg and oct_if.
//
// After reset the block sweeps the link memory, one entry per cycle, and accepts no
// command word until that pass is done. Each command word then yields one result word.
// Read, cancel of the head and a record that makes the first entry pass through
// ST_READ_E and ST_FINISH; a record behind an existing tail adds ST_REC_TAIL. Cancel of
// another listed entity walks from the head in ST_WALK with one link-memory read
// per cycle, then ST_UNLINK if found; the link memory has one write port and a registered
// read. A finished result waits in an output register while the next word is taken.
module ordered_change_tracker #(
    parameter int unsigned ENTITIES = oct_pkg::DEF_ENTITIES
) (
    input  logic              clk,
    input  logic              rst_n,
    oct_in_if.sink            req,
    oct_out_if.source         rsp
);

    localparam int unsigned IW  = $clog2(ENTITIES);
    localparam int unsigned CW  = $clog2(ENTITIES + 1);
    localparam int unsigned MW  = oct_pkg::LINK_W + IW;
    localparam int unsigned WW  = oct_pkg::WIDE_W;

    logic [MW-1:0]                mem [ENTITIES];
    logic [MW-1:0]                rdata_reg;
    logic                         we;
    logic [IW-1:0]                waddr;
    logic [MW-1:0]                wdata;
    logic [IW-1:0]                raddr;

    oct_pkg::state_t              state_reg, state_next;
    logic [IW-1:0]                clr_reg, clr_next;
    logic [oct_pkg::CMD_W-1:0]    cmd_reg, cmd_next;
    logic [IW-1:0]                ent_reg, ent_next;
    logic [oct_pkg::LINK_W-1:0]   est_reg, est_next;
    logic [IW-1:0]                enx_reg, enx_next;
    logic [IW-1:0]                row_reg, row_next;
    logic [CW-1:0]                steps_reg, steps_next;
    logic                         head_valid_reg, head_valid_next;
    logic [IW-1:0]                head_reg, head_next;
    logic                         tail_valid_reg, tail_valid_next;
    logic [IW-1:0]                tail_reg, tail_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [oct_pkg::LINK_W-1:0]   res_status_reg, res_status_next;
    logic [IW-1:0]                res_next_reg, res_next_next;
    logic                         res_alt_reg, res_alt_next;

    logic                         out_valid_reg, out_valid_next;
    logic [oct_pkg::LINK_W-1:0]   out_status_reg, out_status_next;
    logic [oct_pkg::ENTITY_W-1:0] out_next_reg, out_next_next;
    logic [oct_pkg::ENTITY_W-1:0] out_head_reg, out_head_next;
    logic                         out_empty_reg, out_empty_next;
    logic [oct_pkg::COUNT_W-1:0]  out_count_reg, out_count_next;
    logic                         out_alt_reg, out_alt_next;

    logic [WW-1:0]                ent_wide;
    logic                         ent_in_range;
    logic [oct_pkg::LINK_W-1:0]   rd_state;
    logic [IW-1:0]                rd_link;
    logic                         row_in_range;
    logic                         out_free;
    logic                         accept;
    logic [WW-1:0]                head_wide;
    logic [WW-1:0]                rnext_wide;
    logic [WW-1:0]                count_wide;

    assign ent_wide     = WW'(req.entity);
    assign ent_in_range = ent_wide < WW'(ENTITIES);
    assign rd_state     = rdata_reg[MW-1:IW];
    assign rd_link      = rdata_reg[IW-1:0];
    assign row_in_range = WW'(row_reg) < WW'(ENTITIES);
    assign out_free     = !out_valid_reg || rsp.ready;
    assign req.ready    = (state_reg == oct_pkg::ST_IDLE);
    assign accept       = req.valid && req.ready;
    assign head_wide    = WW'(head_reg);
    assign rnext_wide   = WW'(res_next_reg);
    assign count_wide   = WW'(count_reg);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        cmd_next        = cmd_reg;
        ent_next        = ent_reg;
        est_next        = est_reg;
        enx_next        = enx_reg;
        row_next        = row_reg;
        steps_next      = steps_reg;
        head_valid_next = head_valid_reg;
        head_next       = head_reg;
        tail_valid_next = tail_valid_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_next_next   = res_next_reg;
        res_alt_next    = res_alt_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_next_next   = out_next_reg;
        out_head_next   = out_head_reg;
        out_empty_next  = out_empty_reg;
        out_count_next  = out_count_reg;
        out_alt_next    = out_alt_reg;
        we              = 1'b0;
        waddr           = ent_reg;
        wdata           = {oct_pkg::LINK_OUT, IW'(0)};
        raddr           = ent_wide[IW-1:0];

        unique case (state_reg)
            oct_pkg::ST_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg;
                wdata = {oct_pkg::LINK_OUT, IW'(0)};
                clr_next = clr_reg + IW'(1);
                if (WW'(clr_reg) == WW'(ENTITIES - 1))
                begin
                    state_next = oct_pkg::ST_IDLE;
                end
            end

            oct_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next        = req.command;
                    ent_next        = ent_wide[IW-1:0];
                    res_status_next = oct_pkg::LINK_OUT;
                    res_next_next   = IW'(0);
                    res_alt_next    = 1'b0;
                    state_next      = ent_in_range ? oct_pkg::ST_READ_E
                                                   : oct_pkg::ST_FINISH;
                end
            end

            oct_pkg::ST_READ_E:
            begin
                est_next        = rd_state;
                enx_next        = rd_link;
                res_status_next = rd_state;
                res_next_next   = (rd_state == oct_pkg::LINK_NEXT) ? rd_link : IW'(0);
                state_next      = oct_pkg::ST_FINISH;
                case (cmd_reg)
                    oct_pkg::CMD_RECORD:
                    begin
                        if (rd_state == oct_pkg::LINK_OUT)
                        begin
                            we              = 1'b1;
                            waddr           = ent_reg;
                            wdata           = {oct_pkg::LINK_TAIL, IW'(0)};
                            res_status_next = oct_pkg::LINK_TAIL;
                            res_next_next   = IW'(0);
                            res_alt_next    = 1'b1;
                            if (tail_valid_reg)
                            begin
                                state_next = oct_pkg::ST_REC_TAIL;
                            end
                            else
                            begin
                                head_next       = ent_reg;
                                head_valid_next = 1'b1;
                                tail_next       = ent_reg;
                                tail_valid_next = 1'b1;
                                count_next      = count_reg + CW'(1);
                            end
                        end
                    end
                    oct_pkg::CMD_CANCEL:
                    begin
                        if (rd_state != oct_pkg::LINK_OUT && head_valid_reg)
                        begin
                            if (head_reg == ent_reg)
                            begin
                                if (rd_state == oct_pkg::LINK_NEXT)
                                begin
                                    head_next = rd_link;
                                end
                                else
                                begin
                                    head_valid_next = 1'b0;
                                    head_next       = IW'(0);
                                    tail_valid_next = 1'b0;
                                    tail_next       = IW'(0);
                                end
                                we              = 1'b1;
                                waddr           = ent_reg;
                                wdata           = {oct_pkg::LINK_OUT, IW'(0)};
                                count_next      = count_reg - CW'(1);
                                res_status_next = oct_pkg::LINK_OUT;
                                res_next_next   = IW'(0);
                                res_alt_next    = 1'b1;
                            end
                            else
                            begin
                                raddr      = head_reg;
                                row_next   = head_reg;
                                steps_next = CW'(0);
                                state_next = oct_pkg::ST_WALK;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            oct_pkg::ST_REC_TAIL:
            begin
                we         = 1'b1;
                waddr      = tail_reg;
                wdata      = {oct_pkg::LINK_NEXT, ent_reg};
                tail_next  = ent_reg;
                count_next = count_reg + CW'(1);
                state_next = oct_pkg::ST_FINISH;
            end

            oct_pkg::ST_WALK:
            begin
                if (!row_in_range || rd_state != oct_pkg::LINK_NEXT)
                begin
                    state_next = oct_pkg::ST_FINISH;
                end
                else if (rd_link == ent_reg)
                begin
                    we    = 1'b1;
                    waddr = row_reg;
                    wdata = {est_reg, (est_reg == oct_pkg::LINK_NEXT) ? enx_reg : IW'(0)};
                    if (tail_valid_reg && tail_reg == ent_reg)
                    begin
                        tail_next = row_reg;
                    end
                    count_next      = count_reg - CW'(1);
                    res_status_next = oct_pkg::LINK_OUT;
                    res_next_next   = IW'(0);
                    res_alt_next    = 1'b1;
                    state_next      = oct_pkg::ST_UNLINK;
                end
                else if (steps_reg == CW'(ENTITIES - 1))
                begin
                    state_next = oct_pkg::ST_FINISH;
                end
                else
                begin
                    raddr      = rd_link;
                    row_next   = rd_link;
                    steps_next = steps_reg + CW'(1);
                end
            end

            oct_pkg::ST_UNLINK:
            begin
                we         = 1'b1;
                waddr      = ent_reg;
                wdata      = {oct_pkg::LINK_OUT, IW'(0)};
                state_next = oct_pkg::ST_FINISH;
            end

            oct_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_next_next   = rnext_wide[oct_pkg::ENTITY_W-1:0];
                    out_head_next   = head_valid_reg ? head_wide[oct_pkg::ENTITY_W-1:0]
                                                     : oct_pkg::ENTITY_W'(0);
                    out_empty_next  = (count_reg == CW'(0));
                    out_count_next  = count_wide[oct_pkg::COUNT_W-1:0];
                    out_alt_next    = res_alt_reg;
                    state_next      = oct_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = oct_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= oct_pkg::ST_CLEAR;
            clr_reg        <= '0;
            head_valid_reg <= 1'b0;
            head_reg       <= '0;
            tail_valid_reg <= 1'b0;
            tail_reg       <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            head_valid_reg <= head_valid_next;
            head_reg       <= head_next;
            tail_valid_reg <= tail_valid_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        ent_reg        <= ent_next;
        est_reg        <= est_next;
        enx_reg        <= enx_next;
        row_reg        <= row_next;
        steps_reg      <= steps_next;
        res_status_reg <= res_status_next;
        res_next_reg   <= res_next_next;
        res_alt_reg    <= res_alt_next;
        out_status_reg <= out_status_next;
        out_next_reg   <= out_next_next;
        out_head_reg   <= out_head_next;
        out_empty_reg  <= out_empty_next;
        out_count_reg  <= out_count_next;
        out_alt_reg    <= out_alt_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.link_status  = out_status_reg;
    assign rsp.next_entity  = out_next_reg;
    assign rsp.head_entity  = out_head_reg;
    assign rsp.list_empty   = out_empty_reg;
    assign rsp.change_count = out_count_reg;
    assign rsp.list_altered = out_alt_reg;

    // Head and tail exist together, and only while the list holds entries.
    a_head_tail: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid_reg == tail_valid_reg)
        else $error("head and tail validity disagree");

    a_count_head: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CW'(0)) == !head_valid_reg)
        else $error("entry count disagrees with head validity");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != oct_pkg::ST_IDLE)
        else $error("command word accepted without leaving idle");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == oct_pkg::ST_FINISH && out_free) |=> out_valid_reg)
        else $error("finished command did not present a result word");

endmodule

// ===== tb/ordered_change_tracker_tb.sv =====
// Self-checking testbench for ordered_change_tracker: drives record, cancel and read words
// and checks every result word against an in-bench list tracker. Depends on oct_pkg, oct_if.
module ordered_change_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [oct_pkg::CMD_W-1:0] CMD_SPARE    = 2'd3;
    localparam int unsigned               LIMIT_CYCLES = 2_000_000;
    localparam int unsigned               MAX_LISTED   = 120;
    localparam int unsigned               HOT_COUNT    = 48;
    localparam int unsigned               N_ENT        = oct_pkg::DEF_ENTITIES;

    typedef struct packed {
        logic [oct_pkg::CMD_W-1:0]    command;
        logic [oct_pkg::ENTITY_W-1:0] entity;
    } change_word_t;

    typedef struct packed {
        logic [oct_pkg::LINK_W-1:0]   link_status;
        logic [oct_pkg::ENTITY_W-1:0] next_entity;
        logic [oct_pkg::ENTITY_W-1:0] head_entity;
        logic                         list_empty;
        logic [oct_pkg::COUNT_W-1:0]  change_count;
        logic                         list_altered;
    } link_report_t;

    logic clk;
    logic rst_n;

    oct_in_if  req_if ();
    oct_out_if rsp_if ();

    ordered_change_tracker #(
        .ENTITIES (oct_pkg::DEF_ENTITIES)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    change_word_t                 change_words [$];
    link_report_t                 predicted_links [$];

    logic [oct_pkg::LINK_W-1:0]   trk_state [N_ENT];
    logic [oct_pkg::ENTITY_W-1:0] trk_next  [N_ENT];
    logic                         trk_head_ok;
    logic [oct_pkg::ENTITY_W-1:0] trk_head;
    logic                         trk_tail_ok;
    logic [oct_pkg::ENTITY_W-1:0] trk_tail;
    int unsigned                  trk_count;
    int unsigned                  trk_peak;

    bit                           gen_listed [N_ENT];
    logic [oct_pkg::ENTITY_W-1:0] gen_members [$];
    logic [oct_pkg::ENTITY_W-1:0] hot_entities [HOT_COUNT];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned words_by_cmd [4];
    int unsigned reports_checked;
    int unsigned error_count;
    int unsigned cycle_count;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic link_report_t track_change(input logic [oct_pkg::CMD_W-1:0] cmd,
                                                  input logic [oct_pkg::ENTITY_W-1:0] ent);
        link_report_t                 rep;
        logic                         altered;
        logic                         walking;
        logic [oct_pkg::ENTITY_W-1:0] row;
        altered = 1'b0;
        if (cmd == oct_pkg::CMD_RECORD)
        begin
            if (trk_state[ent] == oct_pkg::LINK_OUT)
            begin
                trk_state[ent] = oct_pkg::LINK_TAIL;
                trk_next[ent]  = '0;
                if (trk_tail_ok)
                begin
                    trk_state[trk_tail] = oct_pkg::LINK_NEXT;
                    trk_next[trk_tail]  = ent;
                end
                else
                begin
                    trk_head    = ent;
                    trk_head_ok = 1'b1;
                end
                trk_tail    = ent;
                trk_tail_ok = 1'b1;
                trk_count++;
                altered = 1'b1;
            end
        end
        else if (cmd == oct_pkg::CMD_CANCEL && trk_state[ent] != oct_pkg::LINK_OUT
                 && trk_head_ok)
        begin
            if (trk_head == ent)
            begin
                if (trk_state[ent] == oct_pkg::LINK_NEXT)
                    trk_head = trk_next[ent];
                else
                begin
                    trk_head_ok = 1'b0;
                    trk_head    = '0;
                    trk_tail_ok = 1'b0;
                    trk_tail    = '0;
                end
                trk_state[ent] = oct_pkg::LINK_OUT;
                trk_next[ent]  = '0;
                trk_count--;
                altered = 1'b1;
            end
            else
            begin
                row     = trk_head;
                walking = 1'b1;
                for (int hop = 0; hop < N_ENT && walking; hop++)
                begin
                    if (trk_state[row] != oct_pkg::LINK_NEXT)
                        walking = 1'b0;
                    else if (trk_next[row] == ent)
                    begin
                        trk_state[row] = trk_state[ent];
                        trk_next[row]  = (trk_state[ent] == oct_pkg::LINK_NEXT)
                                         ? trk_next[ent] : '0;
                        trk_state[ent] = oct_pkg::LINK_OUT;
                        trk_next[ent]  = '0;
                        if (trk_tail_ok && trk_tail == ent)
                            trk_tail = row;
                        trk_count--;
                        altered = 1'b1;
                        walking = 1'b0;
                    end
                    else
                        row = trk_next[row];
                end
            end
        end
        if (trk_count > trk_peak)
            trk_peak = trk_count;
        rep.link_status  = trk_state[ent];
        rep.next_entity  = (trk_state[ent] == oct_pkg::LINK_NEXT) ? trk_next[ent] : '0;
        rep.head_entity  = trk_head_ok ? trk_head : '0;
        rep.list_empty   = (trk_count == 0);
        rep.change_count = trk_count[oct_pkg::COUNT_W-1:0];
        rep.list_altered = altered;
        return rep;
    endfunction

    task automatic enqueue_word(input logic [oct_pkg::CMD_W-1:0] cmd,
                                input logic [oct_pkg::ENTITY_W-1:0] ent);
        change_word_t w;
        w.command = cmd;
        w.entity  = ent;
        change_words.push_back(w);
        if (cmd == oct_pkg::CMD_RECORD && !gen_listed[ent])
        begin
            gen_listed[ent] = 1'b1;
            gen_members.push_back(ent);
        end
        else if (cmd == oct_pkg::CMD_CANCEL && gen_listed[ent])
        begin
            gen_listed[ent] = 1'b0;
            for (int i = 0; i < gen_members.size(); i++)
                if (gen_members[i] == ent)
                    gen_members.delete(i);
        end
    endtask

    function automatic logic [oct_pkg::ENTITY_W-1:0] pick_entity();
        if ($urandom_range(99) < 70)
            return hot_entities[$urandom_range(HOT_COUNT - 1)];
        return oct_pkg::ENTITY_W'($urandom_range(N_ENT - 1));
    endfunction

    function automatic logic [oct_pkg::ENTITY_W-1:0] pick_member();
        return gen_members[$urandom_range(gen_members.size() - 1)];
    endfunction

    task automatic add_random_words(input int unsigned n);
        logic [oct_pkg::CMD_W-1:0]    cmd;
        logic [oct_pkg::ENTITY_W-1:0] ent;
        int unsigned                  roll;
        repeat (n)
        begin
            roll = $urandom_range(99);
            ent  = pick_entity();
            if (gen_members.size() > MAX_LISTED)
            begin
                cmd = oct_pkg::CMD_CANCEL;
                ent = pick_member();
            end
            else if (roll < 40)
                cmd = oct_pkg::CMD_RECORD;
            else if (roll < 75)
            begin
                cmd = oct_pkg::CMD_CANCEL;
                if (gen_members.size() > 0 && $urandom_range(99) < 60)
                    ent = pick_member();
            end
            else if (roll < 95)
            begin
                cmd = oct_pkg::CMD_READ;
                if (gen_members.size() > 0 && $urandom_range(1) == 1)
                    ent = pick_member();
            end
            else
                cmd = CMD_SPARE;
            enqueue_word(cmd, ent);
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (change_words.size() != 0 || req_if.valid || predicted_links.size() != 0);
    endtask

    // Driver: predict on acceptance, then offer the next word or idle.
    always @(posedge clk)
    begin
        if (!rst_n)
            req_if.valid <= 1'b0;
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                predicted_links.push_back(track_change(req_if.command, req_if.entity));
                words_by_cmd[req_if.command]++;
            end
            if (!req_if.valid || req_if.ready)
            begin
                if (change_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_if.valid   <= 1'b1;
                    req_if.command <= change_words[0].command;
                    req_if.entity  <= change_words[0].entity;
                    change_words.pop_front();
                end
                else
                    req_if.valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result word with the oldest prediction.
    always @(posedge clk)
    begin
        link_report_t got;
        link_report_t want;
        if (!rst_n)
            rsp_if.ready <= 1'b0;
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                got.link_status  = rsp_if.link_status;
                got.next_entity  = rsp_if.next_entity;
                got.head_entity  = rsp_if.head_entity;
                got.list_empty   = rsp_if.list_empty;
                got.change_count = rsp_if.change_count;
                got.list_altered = rsp_if.list_altered;
                if (predicted_links.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("[%0t] unexpected result word: %p", $realtime, got);
                end
                else
                begin
                    want = predicted_links.pop_front();
                    reports_checked++;
                    if (got.link_status  !== want.link_status  ||
                        got.next_entity  !== want.next_entity  ||
                        got.head_entity  !== want.head_entity  ||
                        got.list_empty   !== want.list_empty   ||
                        got.change_count !== want.change_count ||
                        got.list_altered !== want.list_altered)
                    begin
                        error_count++;
                        if (error_count <= 10)
                        begin
                            $display("[%0t] mismatch on result word %0d", $realtime,
                                     reports_checked);
                            $display("  expected %p", want);
                            $display("  actual   %p", got);
                        end
                    end
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        req_if.valid   = 1'b0;
        req_if.command = oct_pkg::CMD_READ;
        req_if.entity  = '0;
        rsp_if.ready   = 1'b0;
        cycle_count    = 0;
        error_count    = 0;
        reports_checked = 0;
        trk_head_ok    = 1'b0;
        trk_head       = '0;
        trk_tail_ok    = 1'b0;
        trk_tail       = '0;
        trk_count      = 0;
        trk_peak       = 0;
        send_idle_pct  = 34;
        recv_idle_pct  = 50;
        for (int i = 0; i < 4; i++)
            words_by_cmd[i] = 0;
        for (int i = 0; i < N_ENT; i++)
        begin
            trk_state[i]  = oct_pkg::LINK_OUT;
            trk_next[i]   = '0;
            gen_listed[i] = 1'b0;
        end
        hot_entities[0] = '0;
        hot_entities[1] = oct_pkg::ENTITY_W'(N_ENT - 1);
        for (int i = 2; i < HOT_COUNT; i++)
            hot_entities[i] = oct_pkg::ENTITY_W'($urandom_range(N_ENT - 1));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // empty list, duplicates, head/middle/tail removal, spare code
        enqueue_word(oct_pkg::CMD_READ,   10'd0);
        enqueue_word(oct_pkg::CMD_CANCEL, 10'd5);
        enqueue_word(oct_pkg::CMD_RECORD, 10'd0);
        enqueue_word(oct_pkg::CMD_RECORD, 10'd1023);
        enqueue_word(oct_pkg::CMD_RECORD, 10'd0);
        enqueue_word(oct_pkg::CMD_RECORD, 10'd512);
        enqueue_word(oct_pkg::CMD_RECORD, 10'd341);
        enqueue_word(oct_pkg::CMD_RECORD, 10'd682);
        enqueue_word(oct_pkg::CMD_READ,   10'd0);
        enqueue_word(CMD_SPARE,           10'd1023);
        enqueue_word(oct_pkg::CMD_CANCEL, 10'd512);
        enqueue_word(oct_pkg::CMD_CANCEL, 10'd682);
        enqueue_word(oct_pkg::CMD_RECORD, 10'd100);
        enqueue_word(oct_pkg::CMD_CANCEL, 10'd0);
        enqueue_word(oct_pkg::CMD_CANCEL, 10'd0);
        enqueue_word(oct_pkg::CMD_READ,   10'd1023);
        enqueue_word(CMD_SPARE,           10'd0);
        enqueue_word(oct_pkg::CMD_CANCEL, 10'd100);
        enqueue_word(oct_pkg::CMD_CANCEL, 10'd341);
        enqueue_word(oct_pkg::CMD_CANCEL, 10'd1023);
        enqueue_word(oct_pkg::CMD_RECORD, 10'd7);
        enqueue_word(oct_pkg::CMD_CANCEL, 10'd7);
        enqueue_word(oct_pkg::CMD_READ,   10'd7);

        add_random_words(430);
        wait_drained();

        send_idle_pct = 50;
        recv_idle_pct = 34;
        add_random_words(430);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_words(420);
        wait_drained();

        repeat (64) @(posedge clk);
        $display("Ran %0d words (%0d record, %0d cancel, %0d read, %0d spare code), %0d checked",
                 words_by_cmd[0] + words_by_cmd[1] + words_by_cmd[2] + words_by_cmd[3],
                 words_by_cmd[oct_pkg::CMD_RECORD], words_by_cmd[oct_pkg::CMD_CANCEL],
                 words_by_cmd[oct_pkg::CMD_READ], words_by_cmd[CMD_SPARE], reports_checked);
        $display("Longest list held %0d entities; %0d errors", trk_peak, error_count);
        if (error_count == 0 && predicted_links.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
